// File: hw/rtl/button_debounce_press_classifier_top_macros.svh
// Assertion macros shared by the button classifier RTL.
// Needs nothing else; files that assert include it by name.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define BDPC_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bdpc assertion failed");

// Antecedent in one cycle implies consequent in the next
`define BDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdpc assertion failed");

`endif

// File: hw/rtl/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Types, widths, codes and reset values used by all RTL files; no dependencies.
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int RAW_W       = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CNT_W       = 8;
    localparam int KIND_W      = 2;
    localparam int IDX_OUT_W   = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
    localparam logic [CFG_W-1:0] MULTI_RST    = CFG_W'(350);
    localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(500);
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE   = 2'd0,
        EV_LONG   = 2'd1,
        EV_REPORT = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] multi_interval_ms;
        logic [CFG_W-1:0] long_press_ms;
    } cfg_t;

    // What one lane found for the current item
    typedef struct packed {
        logic             long_evt;
        logic             rep_evt;
        logic [CNT_W-1:0] rep_cnt;
    } lane_evt_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [IDX_OUT_W-1:0] idx;
        logic [CNT_W-1:0]     cnt;
    } result_t;

endpackage

// File: hw/rtl/bdpc_lane.sv
// One button lane: debounce, press timing, multi-press count and report.
// Depends on bdpc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_top_macros.svh"

module bdpc_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [bdpc_pkg::TIME_W-1:0]   now,
    input  logic                          lvl,
    input  bdpc_pkg::cfg_t                cfg,
    output bdpc_pkg::lane_evt_t           evt
);

    logic                          stable_reg, stable_next;
    logic                          prev_reg, prev_next;
    logic [bdpc_pkg::TIME_W-1:0]   lct_reg, lct_next;
    logic [bdpc_pkg::TIME_W-1:0]   pst_reg, pst_next;
    logic [bdpc_pkg::TIME_W-1:0]   last_reg, last_next;
    logic [bdpc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          pending_reg, pending_next;

    logic [bdpc_pkg::TIME_W-1:0]   age, dur, gap, gap_new;
    logic [bdpc_pkg::TIME_W-1:0]   deb_w, multi_w, long_w;
    logic                          take, counted;
    logic [bdpc_pkg::CNT_W-1:0]    count_mid;
    logic                          pending_mid;

    assign deb_w   = {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
    assign multi_w = {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, cfg.multi_interval_ms};
    assign long_w  = {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, cfg.long_press_ms};

    // Debounce and classify; all differences wrap modulo 2^32
    always_comb
    begin
        prev_next    = lvl;
        lct_next     = (lvl != prev_reg) ? now : lct_reg;
        age          = now - lct_next;
        dur          = now - pst_reg;
        gap          = now - last_reg;
        take         = (age > deb_w) && (lvl != stable_reg);
        stable_next  = stable_reg;
        pst_next     = pst_reg;
        last_next    = last_reg;
        count_mid    = count_reg;
        pending_mid  = pending_reg;
        counted      = 1'b0;
        evt.long_evt = 1'b0;
        if (take)
        begin
            stable_next = lvl;
            if (!lvl)
            begin
                pst_next = now;
            end
            else if (dur > long_w)
            begin
                evt.long_evt = 1'b1;
                count_mid    = '0;
                pending_mid  = 1'b0;
            end
            else if (dur != '0)
            begin
                counted = 1'b1;
                if (gap <= multi_w)
                begin
                    if (count_reg != bdpc_pkg::CNT_MAX)
                    begin
                        count_mid = count_reg + 1'b1;
                    end
                end
                else
                begin
                    count_mid = bdpc_pkg::CNT_W'(1);
                end
                last_next   = now;
                pending_mid = 1'b1;
            end
        end

        // Pending report fires once the interval since the last press has passed
        gap_new      = counted ? '0 : gap;
        evt.rep_evt  = pending_mid && (gap_new > multi_w) && (count_mid != '0);
        evt.rep_cnt  = count_mid;
        count_next   = evt.rep_evt ? '0 : count_mid;
        pending_next = evt.rep_evt ? 1'b0 : pending_mid;
    end

    // Lane state, updated only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg  <= 1'b0;
            prev_reg    <= 1'b0;
            lct_reg     <= '0;
            pst_reg     <= '0;
            last_reg    <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            stable_reg  <= stable_next;
            prev_reg    <= prev_next;
            lct_reg     <= lct_next;
            pst_reg     <= pst_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    `BDPC_ASSERT_ALWAYS(a_pending_has_count, clk, rst_n, !pending_reg || (count_reg != '0))
    `BDPC_ASSERT_ALWAYS(a_events_exclusive, clk, rst_n, !(evt.long_evt && evt.rep_evt))
    `BDPC_ASSERT_NEXT(a_report_clears, clk, rst_n, fire && evt.rep_evt,
                      !pending_reg && (count_reg == '0))

endmodule

// File: hw/rtl/bdpc_merge.sv
// Merge stage: picks the last event written across lanes for one item.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_merge (
    input  bdpc_pkg::lane_evt_t [bdpc_pkg::NUM_BUTTONS-1:0] evts,
    output bdpc_pkg::result_t                               res
);

    // Long presses in lane order, then reports in lane order; later wins
    always_comb
    begin
        res.kind = bdpc_pkg::EV_NONE;
        res.idx  = '0;
        res.cnt  = '0;
        for (int i = 0; i < bdpc_pkg::NUM_BUTTONS; i++)
        begin
            if (evts[i].long_evt)
            begin
                res.kind = bdpc_pkg::EV_LONG;
                res.idx  = bdpc_pkg::IDX_OUT_W'(i);
                res.cnt  = '0;
            end
        end
        for (int i = 0; i < bdpc_pkg::NUM_BUTTONS; i++)
        begin
            if (evts[i].rep_evt)
            begin
                res.kind = bdpc_pkg::EV_REPORT;
                res.idx  = bdpc_pkg::IDX_OUT_W'(i);
                res.cnt  = evts[i].rep_cnt;
            end
        end
    end

endmodule

// File: hw/rtl/bdpc_obuf.sv
// Two-entry output queue between the merge stage and the result channel.
// Depends on bdpc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_top_macros.svh"

module bdpc_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bdpc_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output bdpc_pkg::result_t out_data
);

    bdpc_pkg::result_t mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BDPC_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg != 2'd3)
    `BDPC_ASSERT_ALWAYS(a_no_push_full, clk, rst_n, !(push && full))
    `BDPC_ASSERT_NEXT(a_push_shows, clk, rst_n, push, out_valid)

endmodule

// File: hw/rtl/button_debounce_press_classifier_top.sv
// Each accepted poll's merged result is registered in the output queue.
// Throughput: one poll per cycle while the input is not stalled; all button lanes update in the accept cycle.
// A two-entry output queue takes polls while a result waits; input stalls when full.
// Reset (rst_n, async low) clears lane state to zero and loads the
// configuration registers with 50, 350 and 500 ms.
// Depends on bdpc_pkg, bdpc_lane, bdpc_merge, bdpc_obuf and the macro header.
`timescale 1ns / 1ps

module button_debounce_press_classifier_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bdpc_pkg::TIME_W-1:0]         now_ms,
    input  logic [bdpc_pkg::RAW_W-1:0]          raw_levels,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bdpc_pkg::KIND_W-1:0]         event_kind,
    output logic [bdpc_pkg::IDX_OUT_W-1:0]      button_index,
    output logic [bdpc_pkg::CNT_W-1:0]          press_count
);

    bdpc_pkg::cfg_t                                  cfg_reg, cfg_next;
    bdpc_pkg::lane_evt_t [bdpc_pkg::NUM_BUTTONS-1:0] evts;
    bdpc_pkg::result_t                               merged, out_res;
    logic                                            fire, full;

    assign in_stall = full;
    assign fire     = in_valid && !full;

    // Configuration register writes; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bdpc_pkg::CFG_DEBOUNCE: cfg_next.debounce_ms       = cfg_wdata;
                bdpc_pkg::CFG_MULTI:    cfg_next.multi_interval_ms = cfg_wdata;
                bdpc_pkg::CFG_LONG:     cfg_next.long_press_ms     = cfg_wdata;
                default:                cfg_next                   = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= bdpc_pkg::DEBOUNCE_RST;
            cfg_reg.multi_interval_ms <= bdpc_pkg::MULTI_RST;
            cfg_reg.long_press_ms     <= bdpc_pkg::LONG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // One lane per button; buttons past the raw field read as pressed
    for (genvar g = 0; g < bdpc_pkg::NUM_BUTTONS; g++)
    begin : g_lane
        logic lvl;
        if (g < bdpc_pkg::RAW_W)
        begin : g_raw
            assign lvl = raw_levels[g];
        end
        else
        begin : g_zero
            assign lvl = 1'b0;
        end

        bdpc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .fire  (fire),
            .now   (now_ms),
            .lvl   (lvl),
            .cfg   (cfg_reg),
            .evt   (evts[g])
        );
    end

    bdpc_merge u_merge (
        .evts (evts),
        .res  (merged)
    );

    bdpc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (merged),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign event_kind   = out_res.kind;
    assign button_index = out_res.idx;
    assign press_count  = out_res.cnt;

endmodule

// File: sim/tb.sv
// Testbench for button_debounce_press_classifier_top: directed and random polls are checked
// against a cycle-free predictor of the debounce and press classification rules.
// Depends on bdpc_pkg and the RTL of the classifier.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index = bdpc_pkg::CFG_DEBOUNCE;
    logic [bdpc_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [bdpc_pkg::TIME_W-1:0]    now_ms = '0;
    logic [bdpc_pkg::RAW_W-1:0]     raw_levels = '1;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [bdpc_pkg::KIND_W-1:0]    event_kind;
    logic [bdpc_pkg::IDX_OUT_W-1:0] button_index;
    logic [bdpc_pkg::CNT_W-1:0]     press_count;

    // Predictor state per button
    logic                        settled_level [bdpc_pkg::NUM_BUTTONS];
    logic                        last_raw      [bdpc_pkg::NUM_BUTTONS];
    logic [bdpc_pkg::TIME_W-1:0] change_at     [bdpc_pkg::NUM_BUTTONS];
    logic [bdpc_pkg::TIME_W-1:0] press_at      [bdpc_pkg::NUM_BUTTONS];
    logic [bdpc_pkg::TIME_W-1:0] counted_at    [bdpc_pkg::NUM_BUTTONS];
    logic [bdpc_pkg::CNT_W-1:0]  click_count   [bdpc_pkg::NUM_BUTTONS];
    logic                        report_due    [bdpc_pkg::NUM_BUTTONS];
    logic [bdpc_pkg::CFG_W-1:0]  debounce_cfg;
    logic [bdpc_pkg::CFG_W-1:0]  multi_cfg;
    logic [bdpc_pkg::CFG_W-1:0]  long_cfg;

    bdpc_pkg::result_t           pending_events [$];
    int                          mismatches = 0;
    bit                          no_idle = 1'b0;
    bit                          hold_request = 1'b0;
    logic [bdpc_pkg::TIME_W-1:0] clock_ms = '0;
    logic [bdpc_pkg::RAW_W-1:0]  button_levels = '1;

    button_debounce_press_classifier_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .raw_levels   (raw_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .button_index (button_index),
        .press_count  (press_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Predictor: reset state, levels low (pressed)
    function automatic void clear_classifier();
        int i;
        for (i = 0; i < bdpc_pkg::NUM_BUTTONS; i++)
        begin
            settled_level[i] = 1'b0;
            last_raw[i]      = 1'b0;
            change_at[i]     = '0;
            press_at[i]      = '0;
            counted_at[i]    = '0;
            click_count[i]   = '0;
            report_due[i]    = 1'b0;
        end
        debounce_cfg = bdpc_pkg::DEBOUNCE_RST;
        multi_cfg    = bdpc_pkg::MULTI_RST;
        long_cfg     = bdpc_pkg::LONG_RST;
    endfunction

    // Predictor: one poll, returns the last event written
    function automatic bdpc_pkg::result_t classify_poll(
        input logic [bdpc_pkg::TIME_W-1:0] stamp,
        input logic [bdpc_pkg::RAW_W-1:0]  raw);
        bdpc_pkg::result_t           res;
        logic                        lvl;
        logic [bdpc_pkg::TIME_W-1:0] held;
        logic [bdpc_pkg::TIME_W-1:0] span;
        logic [bdpc_pkg::TIME_W-1:0] since;
        int                          i;
        res.kind = bdpc_pkg::EV_NONE;
        res.idx  = '0;
        res.cnt  = '0;
        for (i = 0; i < bdpc_pkg::NUM_BUTTONS; i++)
        begin
            lvl = raw[i];
            if (lvl != last_raw[i])
                change_at[i] = stamp;
            held = stamp - change_at[i];
            if (held > debounce_cfg && lvl != settled_level[i])
            begin
                settled_level[i] = lvl;
                if (!lvl)
                    press_at[i] = stamp;
                else
                begin
                    span = stamp - press_at[i];
                    if (span > long_cfg)
                    begin
                        res.kind       = bdpc_pkg::EV_LONG;
                        res.idx        = bdpc_pkg::IDX_OUT_W'(i);
                        res.cnt        = '0;
                        click_count[i] = '0;
                        report_due[i]  = 1'b0;
                    end
                    else if (span != 0)
                    begin
                        since = stamp - counted_at[i];
                        if (since <= multi_cfg)
                        begin
                            if (click_count[i] != bdpc_pkg::CNT_MAX)
                                click_count[i] = click_count[i] + 1'b1;
                        end
                        else
                            click_count[i] = bdpc_pkg::CNT_W'(1);
                        counted_at[i] = stamp;
                        report_due[i] = 1'b1;
                    end
                end
            end
            last_raw[i] = lvl;
        end
        // Reports whose multi-press window has closed
        for (i = 0; i < bdpc_pkg::NUM_BUTTONS; i++)
        begin
            since = stamp - counted_at[i];
            if (report_due[i] && since > multi_cfg && click_count[i] != 0)
            begin
                res.kind       = bdpc_pkg::EV_REPORT;
                res.idx        = bdpc_pkg::IDX_OUT_W'(i);
                res.cnt        = click_count[i];
                click_count[i] = '0;
                report_due[i]  = 1'b0;
            end
        end
        return res;
    endfunction

    // Send one poll item, with random idle cycles ahead of it
    task automatic send_poll(input logic [bdpc_pkg::TIME_W-1:0] stamp,
                             input logic [bdpc_pkg::RAW_W-1:0] levels);
        while (!no_idle && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        now_ms     <= stamp;
        raw_levels <= levels;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_events.push_back(classify_poll(stamp, levels));
    endtask

    // Write all three timing registers once the block has drained
    task automatic set_timing(input logic [bdpc_pkg::CFG_W-1:0] db,
                              input logic [bdpc_pkg::CFG_W-1:0] mi,
                              input logic [bdpc_pkg::CFG_W-1:0] lp);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= bdpc_pkg::CFG_DEBOUNCE;
        cfg_wdata <= db;
        @(posedge clk);
        debounce_cfg = db;
        cfg_index <= bdpc_pkg::CFG_MULTI;
        cfg_wdata <= mi;
        @(posedge clk);
        multi_cfg = mi;
        cfg_index <= bdpc_pkg::CFG_LONG;
        cfg_wdata <= lp;
        @(posedge clk);
        long_cfg = lp;
        cfg_wr_en <= 1'b0;
    endtask

    // Reset levels are pressed, so the first release is timed from zero
    task automatic test_first_release();
        send_poll(32'd5, 8'h00);
        send_poll(32'd1000, 8'hFF);
        send_poll(32'd1100, 8'hFF);
    endtask

    // Press and release taken at the same millisecond: only the level moves
    task automatic test_zero_length_press();
        set_timing(16'd3, 16'd20, 16'd30);
        send_poll(32'd2000, 8'hFE);
        send_poll(32'd2010, 8'hFE);
        send_poll(32'd2000, 8'hFF);
        send_poll(32'd2010, 8'hFF);
    endtask

    // Two short presses inside the window, then the count report
    task automatic test_double_press();
        send_poll(32'd3000, 8'hFE);
        send_poll(32'd3010, 8'hFE);
        send_poll(32'd3011, 8'hFF);
        send_poll(32'd3015, 8'hFF);
        send_poll(32'd3016, 8'hFE);
        send_poll(32'd3020, 8'hFE);
        send_poll(32'd3021, 8'hFF);
        send_poll(32'd3025, 8'hFF);
        send_poll(32'd3046, 8'hFF);
    endtask

    // Long press on one button, then on two at once (higher index wins)
    task automatic test_long_press();
        send_poll(32'd4000, 8'hF7);
        send_poll(32'd4004, 8'hF7);
        send_poll(32'd4040, 8'hFF);
        send_poll(32'd4044, 8'hFF);
        send_poll(32'd5000, 8'hBB);
        send_poll(32'd5004, 8'hBB);
        send_poll(32'd5040, 8'hFF);
        send_poll(32'd5044, 8'hFF);
    endtask

    // Short press across the 32-bit timestamp wrap
    task automatic test_time_wrap();
        send_poll(32'hFFFF_FFF0, 8'h7F);
        send_poll(32'hFFFF_FFF8, 8'h7F);
        send_poll(32'h0000_0002, 8'hFF);
        send_poll(32'h0000_0008, 8'hFF);
        send_poll(32'h0000_0030, 8'hFF);
        clock_ms = 32'h0000_0030;
    endtask

    // A long run of short presses builds a large count, reported at the end
    task automatic test_press_burst();
        int n;
        set_timing(16'd0, 16'hFFFF, 16'hFFFF);
        for (n = 0; n < 40; n++)
        begin
            send_poll(clock_ms, 8'hEF);
            send_poll(clock_ms + 1, 8'hEF);
            send_poll(clock_ms + 2, 8'hFF);
            send_poll(clock_ms + 3, 8'hFF);
            clock_ms = clock_ms + 4;
        end
        clock_ms = clock_ms + 70000;
        send_poll(clock_ms, 8'hFF);
    endtask

    // Receiver holds off while polls keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        hold_request = 1'b1;
        no_idle      = 1'b1;
        for (n = 0; n < 24; n++)
        begin
            clock_ms = clock_ms + $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
                button_levels = button_levels ^ (8'h01 << $urandom_range(0, 7));
            send_poll(clock_ms, button_levels);
        end
        no_idle = 1'b0;
    endtask

    // Button activity with bounces, time jumps and some random levels
    task automatic test_random_traffic(input int polls, input logic [bdpc_pkg::CFG_W-1:0] db,
                                       input logic [bdpc_pkg::CFG_W-1:0] mi,
                                       input logic [bdpc_pkg::CFG_W-1:0] lp,
                                       input int unsigned max_step, input bit steady);
        int unsigned                roll;
        logic [bdpc_pkg::RAW_W-1:0] glitch;
        int                         n;
        int                         b;
        set_timing(db, mi, lp);
        no_idle = steady;
        for (n = 0; n < polls; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                clock_ms = $urandom();
            else if (roll < 10)
                clock_ms = clock_ms + $urandom_range(0, 16 * max_step);
            else
                clock_ms = clock_ms + $urandom_range(0, max_step);
            for (b = 0; b < bdpc_pkg::RAW_W; b++)
                if ($urandom_range(0, 7) == 0)
                    button_levels[b] = ~button_levels[b];
            // single-poll bounce on one button
            glitch = '0;
            if ($urandom_range(0, 9) == 0)
                glitch = 8'h01 << $urandom_range(0, 7);
            if ($urandom_range(0, 49) == 0)
                send_poll(clock_ms, bdpc_pkg::RAW_W'($urandom()));
            else
                send_poll(clock_ms, button_levels ^ glitch);
        end
        no_idle = 1'b0;
    endtask

    // Result checker; also drives the receiver stall
    initial
    begin
        bdpc_pkg::result_t want;
        int                hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: result with no poll waiting: kind %0d button %0d count %0d",
                             $time, event_kind, button_index, press_count);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $time, want.kind, event_kind);
                        mismatches++;
                    end
                    if (button_index !== want.idx)
                    begin
                        $display("%0t: button_index expected %0d actual %0d",
                                 $time, want.idx, button_index);
                        mismatches++;
                    end
                    if (press_count !== want.cnt)
                    begin
                        $display("%0t: press_count expected %0d actual %0d",
                                 $time, want.cnt, press_count);
                        mismatches++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !no_idle && ($urandom_range(0, 99) < 29);
        end
    end

    // Watchdog: too long with no item moving on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Test sequence
    initial
    begin
        clear_classifier();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_release();
        test_zero_length_press();
        test_double_press();
        test_long_press();
        test_time_wrap();
        test_press_burst();
        test_backpressure();
        test_random_traffic(120, 16'd50, 16'd350, 16'd500, 40, 1'b0);
        test_random_traffic(150, 16'd3, 16'd20, 16'd30, 6, 1'b1);
        test_random_traffic(80, 16'd0, 16'd0, 16'd0, 3, 1'b0);
        test_random_traffic(60, 16'hFFFF, 16'hFFFF, 16'hFFFF, 30000, 1'b0);
        test_random_traffic(100, bdpc_pkg::CFG_W'($urandom_range(0, 20)),
                            bdpc_pkg::CFG_W'($urandom_range(0, 60)),
                            bdpc_pkg::CFG_W'($urandom_range(0, 80)), 10, 1'b0);

        // Drain and let the pipeline settle
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
